FILE: hw/rtl/dctc_pkg.sv
`timescale 1ns / 1ps
package dctc_pkg;

	localparam int MAX_ORDER_DEF  = 63;
	localparam int MAX_RADIUS_DEF = 255;
	localparam int COS_WIDTH_DEF  = 18;

	localparam int SAMPLE_W = 32;
	localparam int ACC_W    = 48;
	localparam int PHASE_W  = 32;
	// Dividend of the shared divider: phase set-up needs 8+32 bits, the final
	// scaling needs 50 bits.
	localparam int DVD_W    = 52;
	// Divisor: 2*T is at most 1024.
	localparam int DSR_W    = 11;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 8;

	typedef enum logic [CFG_AW-1:0] {
		REG_DCT_TYPE = 2'd0,
		REG_RADIUS   = 2'd1,
		REG_ORDER    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

endpackage

FILE: hw/rtl/dctc_ram.sv
`timescale 1ns / 1ps
module dctc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/dctc_div.sv
`timescale 1ns / 1ps
module dctc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dctc_pkg::div_req_t req,
	output dctc_pkg::div_rsp_t rsp
);

	localparam int DVD_W = dctc_pkg::DVD_W;
	localparam int DSR_W = dctc_pkg::DSR_W;
	localparam int CW    = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] a_q;
	logic [DSR_W-1:0] r_q;
	logic [DSR_W-1:0] d_q;

	logic [DSR_W:0]   trial;
	logic             fits;

	// Restoring division, one quotient bit a cycle; quotient bits shift in
	// behind the dividend bits.
	assign trial = {r_q, a_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			a_q <= {a_q[DVD_W-2:0], fits};
			r_q <= fits ? DSR_W'(trial - {1'b0, d_q}) : trial[DSR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = a_q;
	assign rsp.remainder = r_q;

endmodule

FILE: hw/rtl/dctc_cos.sv
`timescale 1ns / 1ps
module dctc_cos #(
	parameter int COS_WIDTH = dctc_pkg::COS_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dctc_pkg::PHASE_W-1:0]  phase,
	output logic                          done,
	output logic signed [COS_WIDTH-1:0]   cos_val
);

	localparam int SH = 31 - COS_WIDTH;
	localparam logic [COS_WIDTH-1:0] TOP = COS_WIDTH'((64'd1 << (COS_WIDTH - 1)) - 64'd1);
	localparam logic [31:0] PI_HALF = 32'd1686629713;
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;

	typedef enum logic [8:0] {
		C_IDLE = 9'b000000001,
		C_X    = 9'b000000010,
		C_XR   = 9'b000000100,
		C_SQ   = 9'b000001000,
		C_INIT = 9'b000010000,
		C_TM   = 9'b000100000,
		C_RC   = 9'b001000000,
		C_CR   = 9'b010000000,
		C_AC   = 9'b100000000
	} cos_state_t;

	// Denominator (m+1)(m+2) of each series term, cosine and sine series.
	function automatic logic [7:0] term_div(input logic odd, input logic [2:0] i);
		case ({odd, i})
			4'd0:    return 8'd2;
			4'd1:    return 8'd12;
			4'd2:    return 8'd30;
			4'd3:    return 8'd56;
			4'd4:    return 8'd90;
			4'd5:    return 8'd132;
			4'd6:    return 8'd182;
			4'd8:    return 8'd6;
			4'd9:    return 8'd20;
			4'd10:   return 8'd42;
			4'd11:   return 8'd72;
			4'd12:   return 8'd110;
			4'd13:   return 8'd156;
			4'd14:   return 8'd210;
			default: return 8'd1;
		endcase
	endfunction

	// floor(2^32 / denominator); the quotient it gives is low by at most one.
	function automatic logic [31:0] term_rcp(input logic odd, input logic [2:0] i);
		case ({odd, i})
			4'd0:    return 32'd2147483648;
			4'd1:    return 32'd357913941;
			4'd2:    return 32'd143165576;
			4'd3:    return 32'd76695844;
			4'd4:    return 32'd47721858;
			4'd5:    return 32'd32537631;
			4'd6:    return 32'd23598721;
			4'd8:    return 32'd715827882;
			4'd9:    return 32'd214748364;
			4'd10:   return 32'd102261126;
			4'd11:   return 32'd59652323;
			4'd12:   return 32'd39045157;
			4'd13:   return 32'd27531841;
			4'd14:   return 32'd20452225;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	cos_state_t state_q;
	logic       done_q;
	logic [2:0] i_q;
	logic       usin_q;
	logic       neg_q;
	logic [29:0] f_q;
	logic [63:0] p_q;
	logic [31:0] x_q;
	logic [31:0] x2_q;
	logic [31:0] term_q;
	logic [31:0] v_q;
	logic [31:0] qe_q;
	logic [31:0] rem_q;
	logic signed [33:0] sum_q;
	logic signed [COS_WIDTH-1:0] cos_q;

	logic [1:0]  quad;
	logic [29:0] frac;
	logic        fold;
	logic [30:0] frac_inv;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;
	logic [7:0]  dsel;
	logic [31:0] tnew;
	logic signed [33:0] sum_nx;
	logic [30:0] sclamp;
	logic [31:0] rnd;
	logic [COS_WIDTH-1:0] mag;

	assign quad     = phase[31:30];
	assign frac     = phase[29:0];
	assign fold     = frac >= 30'h2000_0000;
	assign frac_inv = 31'h4000_0000 - {1'b0, frac};
	assign dsel     = term_div(usin_q, i_q);

	always_comb begin
		case (state_q)
			C_X: begin
				ma = {2'b00, f_q};
				mb = PI_HALF;
			end
			C_SQ: begin
				ma = x_q;
				mb = x_q;
			end
			C_TM: begin
				ma = term_q;
				mb = x2_q;
			end
			C_RC: begin
				ma = p_q[61:30];
				mb = term_rcp(usin_q, i_q);
			end
			C_CR: begin
				ma = p_q[63:32];
				mb = {24'd0, dsel};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;
	assign tnew = qe_q + 32'(rem_q >= {24'd0, dsel});
	// The series alternates, starting with a subtraction.
	assign sum_nx = i_q[0] ? sum_q + $signed({2'b00, tnew})
	                       : sum_q - $signed({2'b00, tnew});

	always_comb begin
		if (sum_nx < 0) begin
			sclamp = '0;
		end else if (sum_nx > $signed({2'b00, Q30_ONE})) begin
			sclamp = Q30_ONE[30:0];
		end else begin
			sclamp = sum_nx[30:0];
		end
		rnd = ({1'b0, sclamp} + (32'd1 << (SH - 1))) >> SH;
		mag = rnd[COS_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_X;
					end
				end
				C_X:    state_q <= C_XR;
				C_XR:   state_q <= C_SQ;
				C_SQ:   state_q <= C_INIT;
				C_INIT: begin
					i_q     <= '0;
					state_q <= C_TM;
				end
				C_TM:   state_q <= C_RC;
				C_RC:   state_q <= C_CR;
				C_CR:   state_q <= C_AC;
				C_AC: begin
					if (i_q == 3'd6) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= C_TM;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					f_q    <= fold ? frac_inv[29:0] : frac;
					usin_q <= quad[0] ^ fold;
					neg_q  <= quad[1] ^ quad[0];
				end
			end
			C_X:  p_q <= prod;
			C_XR: x_q <= 32'((p_q + 64'h2000_0000) >> 30);
			C_SQ: p_q <= prod;
			C_INIT: begin
				x2_q   <= p_q[61:30];
				term_q <= usin_q ? x_q : Q30_ONE;
				sum_q  <= usin_q ? $signed({2'b00, x_q}) : $signed({2'b00, Q30_ONE});
			end
			C_TM: p_q <= prod;
			C_RC: begin
				v_q <= p_q[61:30];
				p_q <= prod;
			end
			C_CR: begin
				qe_q  <= p_q[63:32];
				rem_q <= v_q - prod[31:0];
			end
			C_AC: begin
				term_q <= tnew;
				sum_q  <= sum_nx;
				if (i_q == 3'd6) begin
					cos_q <= neg_q ? -$signed(mag) : $signed((mag > TOP) ? TOP : mag);
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign cos_val = cos_q;

endmodule

FILE: hw/rtl/kernel_dct_coefficients.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                  Payload (lowest bit first)
// s_axis    in         tvalid tready tdata      kernel_sample[31:0]
// m_axis    out        tvalid tready tdata tlast coefficient[31:0], coef_index[37:32]
// cfg       in         cfg_wen cfg_addr cfg_wdata dct_type, kernel_radius, max_order
//
// A sample goes through phase set-up on the shared divider, then, for each
// coefficient, through the cosine unit (set-up, then seven series terms) and the
// accumulator read-modify-write.
// After the last sample of a set each coefficient is scaled on the bit-serial
// divider and then waits on m_axis_tready. Reset clears control state and marks
// every accumulator as zero at once. Results are held until taken; no sample
// is taken while a result waits.
module kernel_dct_coefficients #(
	parameter int MAX_ORDER  = dctc_pkg::MAX_ORDER_DEF,
	parameter int MAX_RADIUS = dctc_pkg::MAX_RADIUS_DEF,
	parameter int COS_WIDTH  = dctc_pkg::COS_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // kernel_sample
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [39:0]                  m_axis_tdata,  // coefficient, coef_index, zero pad
	output logic                         m_axis_tlast,  // last_coef
	input  logic                         cfg_wen,
	input  logic [dctc_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [dctc_pkg::CFG_DW-1:0]  cfg_wdata
);

	localparam int AW    = $clog2(MAX_ORDER + 1);
	localparam int ACC_W = dctc_pkg::ACC_W;
	localparam int DSR_W = dctc_pkg::DSR_W;
	localparam int DVD_W = dctc_pkg::DVD_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PDIV  = 9'b000000010,
		S_CGO   = 9'b000000100,
		S_CWAIT = 9'b000001000,
		S_ACC   = 9'b000010000,
		S_ERD   = 9'b000100000,
		S_ENUM  = 9'b001000000,
		S_EWAIT = 9'b010000000,
		S_EOUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [1:0] dct_type_q;
	logic [7:0] radius_q;
	logic [5:0] order_q;
	logic [8:0] count_q;
	logic [5:0] k_q;
	logic [MAX_ORDER:0] valid_q;
	logic signed [31:0] smp_q;
	logic [31:0] phq_q;
	logic [DSR_W-1:0] phr_q;
	logic [31:0] stq_q;
	logic [DSR_W-1:0] str_q;
	logic signed [31+COS_WIDTH:0] prod_q;
	logic neg_q;
	logic [31:0] coef_q;
	logic [5:0] idx_q;
	logic last_q;
	logic tvalid_q;

	logic [7:0] rad;
	logic [5:0] ord;
	logic [9:0] tper;
	logic [DSR_W-1:0] dper;
	logic [8:0] roff;
	logic [7:0] ar;
	logic [DSR_W:0] twice_r;
	logic twice_wrap;
	logic [DSR_W:0] rsum;
	logic rcarry;
	logic signed [ACC_W-1:0] acc_old;
	logic signed [ACC_W:0] num;
	logic [ACC_W:0] nmag;
	logic [DVD_W-1:0] quo;
	logic in_acc;
	logic set_done;

	dctc_pkg::div_req_t div_req;
	dctc_pkg::div_rsp_t div_rsp;

	logic cos_start;
	logic cos_done;
	logic signed [COS_WIDTH-1:0] cos_val;

	logic ram_we;
	logic ram_re;
	logic [ACC_W-1:0] ram_wdata;
	logic [ACC_W-1:0] ram_rdata;

	always_comb begin
		if (radius_q == 8'd0) begin
			rad = 8'd1;
		end else if (32'(radius_q) > MAX_RADIUS) begin
			rad = 8'(MAX_RADIUS);
		end else begin
			rad = radius_q;
		end
		ord = (32'(order_q) > MAX_ORDER) ? 6'(MAX_ORDER) : order_q;
		case (dct_type_q)
			2'd0:    tper = {1'b0, rad, 1'b0};
			2'd1:    tper = {1'b0, rad, 1'b0} + 10'd2;
			default: tper = {1'b0, rad, 1'b0} + 10'd1;
		endcase
		dper = {tper, 1'b0};
	end

	assign roff = (count_q >= {1'b0, rad}) ? count_q - {1'b0, rad} : {1'b0, rad} - count_q;
	assign ar   = roff[7:0];
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign set_done = (10'(count_q) + 10'd1) >= ({1'b0, rad, 1'b0} + 10'd1);

	// Step of the phase walk is twice the divider result ar * 2^32 / D; its remainder is kept as a fraction of D.
	assign twice_r    = {div_rsp.remainder, 1'b0};
	assign twice_wrap = twice_r >= {1'b0, dper};
	assign rsum       = {1'b0, phr_q} + {1'b0, str_q};
	assign rcarry     = rsum >= {1'b0, dper};

	assign acc_old = valid_q[k_q[AW-1:0]] ? $signed(ram_rdata) : '0;
	assign num = (k_q == 6'd0 && !dct_type_q[0]) ? (ACC_W+1)'(acc_old)
	                                             : $signed({acc_old, 1'b0});
	assign nmag = num[ACC_W] ? (ACC_W+1)'(-num) : (ACC_W+1)'(num);
	assign quo  = div_rsp.quotient;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = DVD_W'(ar) << 32;
		div_req.divisor  = dper;
		if (state_q == S_IDLE) begin
			div_req.start = in_acc;
		end else if (state_q == S_ENUM) begin
			div_req.start    = 1'b1;
			div_req.dividend = (DVD_W'(nmag) << 1) + DVD_W'(tper);
			div_req.divisor  = {tper, 1'b0};
		end
	end

	assign cos_start = state_q == S_CGO;
	assign ram_re    = (state_q == S_CGO) || (state_q == S_ERD);
	assign ram_we    = state_q == S_ACC;
	assign ram_wdata = acc_old + ACC_W'(prod_q >>> (COS_WIDTH - 1));

	dctc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dctc_cos #(
		.COS_WIDTH (COS_WIDTH)
	) u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cos_start),
		.phase   (phq_q),
		.done    (cos_done),
		.cos_val (cos_val)
	);

	dctc_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_ORDER + 1)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (k_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (k_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dct_type_q <= 2'd0;
			radius_q   <= 8'd1;
			order_q    <= 6'd0;
			count_q    <= '0;
			k_q        <= '0;
			valid_q    <= '0;
			tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_addr)
					dctc_pkg::REG_DCT_TYPE: dct_type_q <= cfg_wdata[1:0];
					dctc_pkg::REG_RADIUS:   radius_q   <= cfg_wdata;
					dctc_pkg::REG_ORDER:    order_q    <= cfg_wdata[5:0];
					default: ;
				endcase
				if (cfg_addr inside {dctc_pkg::REG_DCT_TYPE, dctc_pkg::REG_RADIUS,
				                     dctc_pkg::REG_ORDER}) begin
					valid_q <= '0;
					count_q <= '0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					if (div_rsp.done) begin
						k_q     <= '0;
						state_q <= S_CGO;
					end
				end
				S_CGO: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (cos_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					valid_q[k_q[AW-1:0]] <= 1'b1;
					if (k_q == ord) begin
						k_q <= '0;
						if (set_done) begin
							state_q <= S_ERD;
						end else begin
							count_q <= count_q + 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_CGO;
					end
				end
				S_ERD:  state_q <= S_ENUM;
				S_ENUM: state_q <= S_EWAIT;
				S_EWAIT: begin
					if (div_rsp.done) begin
						tvalid_q <= 1'b1;
						state_q  <= S_EOUT;
					end
				end
				S_EOUT: begin
					if (m_axis_tready) begin
						tvalid_q <= 1'b0;
						if (last_q) begin
							valid_q <= '0;
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && state_q == S_IDLE) begin
			smp_q <= s_axis_tdata;
		end
		if (state_q == S_PDIV && div_rsp.done) begin
			phq_q <= dct_type_q[0] ? quo[31:0] : '0;
			phr_q <= dct_type_q[0] ? div_rsp.remainder : '0;
			stq_q <= {quo[30:0], 1'b0} + 32'(twice_wrap);
			str_q <= twice_wrap ? DSR_W'(twice_r - {1'b0, dper}) : twice_r[DSR_W-1:0];
		end
		if (state_q == S_CWAIT && cos_done) begin
			prod_q <= smp_q * cos_val;
		end
		if (state_q == S_ACC) begin
			phr_q <= rcarry ? DSR_W'(rsum - {1'b0, dper}) : rsum[DSR_W-1:0];
			phq_q <= phq_q + stq_q + 32'(rcarry);
		end
		if (state_q == S_ENUM) begin
			neg_q <= num[ACC_W];
		end
		if (state_q == S_EWAIT && div_rsp.done) begin
			if (neg_q) begin
				coef_q <= (quo >= (DVD_W'(1) << 31)) ? 32'h8000_0000 : -quo[31:0];
			end else begin
				coef_q <= (quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
			end
			idx_q  <= k_q;
			last_q <= k_q == ord;
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = {2'b00, idx_q, coef_q};
	assign m_axis_tlast  = last_q;

endmodule

FILE: hw/rtl/dctc_checker.sv
`timescale 1ns / 1ps
module dctc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [39:0]                 m_axis_tdata,
	input logic                        m_axis_tlast,
	input logic                        cfg_wen
);

	// A held result keeps its payload until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// The block works on one sample at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("sample request taken while busy");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input open while a result waits");

	// The final coefficient closes the set.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("result after end of set");

	// Register writes arrive only while the block is idle.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |-> s_axis_tready && !m_axis_tvalid)
		else $error("register write while a request is in flight");

endmodule

bind kernel_dct_coefficients dctc_checker u_dctc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.cfg_wen       (cfg_wen)
);

FILE: verif/tb_kernel_dct_coefficients.sv
`timescale 1ns / 1ps
module tb_kernel_dct_coefficients;

	localparam logic [dctc_pkg::CFG_AW-1:0] REG_UNLISTED = 2'd3;
	localparam longint Q30_ONE = 64'd1073741824;
	localparam longint PI_HALF = 64'd1686629713;
	localparam longint COS_TOP = 64'd131071;
	// Enough for a sample at the highest order to finish its accumulation.
	localparam int SETTLE_CYCLES = 2600;

	typedef struct {
		logic [31:0] coef;
		logic [5:0]  idx;
		logic        last;
	} coef_t;

	typedef struct {
		bit                          is_cfg;
		logic [dctc_pkg::CFG_AW-1:0] addr;
		logic [7:0]                  wdata;
		logic [31:0]                 sample;
		bit                          has_exp;
		logic [31:0]                 exp_coef;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [31:0]                   s_axis_tdata = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [39:0]                   m_axis_tdata;
	logic                          m_axis_tlast;
	logic                          cfg_wen = 1'b0;
	logic [dctc_pkg::CFG_AW-1:0]   cfg_addr = '0;
	logic [dctc_pkg::CFG_DW-1:0]   cfg_wdata = '0;

	// Predictor state.
	logic [1:0]  cur_type;
	logic [7:0]  cur_radius;
	logic [5:0]  cur_order;
	longint      acc [64];
	int          sample_cnt;
	coef_t       coef_q[$];

	int errors = 0;
	int items_sent = 0;
	int snd_idle = 9;
	int rcv_idle = 45;

	kernel_dct_coefficients dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void clear_set();
		for (int i = 0; i < 64; i++) acc[i] = 0;
		sample_cnt = 0;
	endfunction

	function automatic longint taylor_q30(input longint x, input bit odd);
		longint x2 = (x * x) >> 30;
		longint term = odd ? x : Q30_ONE;
		longint m = odd ? 1 : 0;
		longint sum = term;
		for (int i = 1; i <= 7; i++) begin
			term = ((term * x2) >> 30) / ((m + 1) * (m + 2));
			m += 2;
			if (i % 2) sum -= term;
			else sum += term;
		end
		if (sum < 0) sum = 0;
		if (sum > Q30_ONE) sum = Q30_ONE;
		return sum;
	endfunction

	function automatic longint cos_q17(input logic [31:0] ph);
		logic [1:0] quad = ph[31:30];
		longint f = longint'(ph[29:0]);
		bit use_sin = quad[0];
		bit neg = (quad == 2'd1) || (quad == 2'd2);
		longint x, mag;
		if (f >= (Q30_ONE >> 1)) begin
			f = Q30_ONE - f;
			use_sin = !use_sin;
		end
		x = (f * PI_HALF + (64'd1 << 29)) >> 30;
		mag = (taylor_q30(x, use_sin) + 4096) >> 13;
		if (!neg && mag > COS_TOP) mag = COS_TOP;
		return neg ? -mag : mag;
	endfunction

	function automatic void predict_coefs(input logic [31:0] data);
		longint rad = (cur_radius == 0) ? 1 : longint'(cur_radius);
		longint half = cur_type[0];
		longint per, dd, ar, nm, ph, smp, num, mag, q;
		coef_t c;
		case (cur_type)
			2'd0: per = 2 * rad;
			2'd1: per = 2 * rad + 2;
			default: per = 2 * rad + 1;
		endcase
		dd = 2 * per;
		smp = longint'($signed(data));
		ar = sample_cnt - rad;
		if (ar < 0) ar = -ar;
		for (int k = 0; k <= cur_order; k++) begin
			nm = ((2 * k + half) * ar) % dd;
			ph = (nm << 32) / dd;
			acc[k] += (smp * cos_q17(ph[31:0])) >>> 17;
		end
		sample_cnt++;
		if (sample_cnt >= 2 * rad + 1) begin
			for (int k = 0; k <= cur_order; k++) begin
				num = acc[k];
				if (!(k == 0 && !cur_type[0])) num *= 2;
				mag = (num < 0) ? -num : num;
				mag = (2 * mag + per) / (2 * per);
				q = (num < 0) ? -mag : mag;
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				c.coef = q[31:0];
				c.idx = k[5:0];
				c.last = (k == cur_order);
				coef_q.push_back(c);
			end
			clear_set();
		end
	endfunction

	// Result side: random backpressure and checking against the oldest expectation.
	always @(posedge clk) begin
		coef_t w;
		m_axis_tready <= ($urandom_range(99) >= rcv_idle);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (coef_q.size() == 0) begin
				report("unexpected result", m_axis_tdata, 0);
			end else begin
				w = coef_q.pop_front();
				if (m_axis_tdata[31:0] !== w.coef) report("coefficient", m_axis_tdata[31:0], w.coef);
				if (m_axis_tdata[37:32] !== w.idx) report("coef_index", m_axis_tdata[37:32], w.idx);
				if (m_axis_tlast !== w.last) report("last_coef", m_axis_tlast, w.last);
			end
		end
	end

	task automatic send_sample(input logic [31:0] data);
		if (items_sent == 60) begin
			snd_idle = 45;
			rcv_idle = 9;
		end else if (items_sent == 120) begin
			snd_idle = 0;
			rcv_idle = 0;
		end
		while ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		predict_coefs(data);
	endtask

	task automatic write_reg(input logic [dctc_pkg::CFG_AW-1:0] addr, input logic [7:0] data);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (coef_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (addr)
			dctc_pkg::REG_DCT_TYPE: cur_type = data[1:0];
			dctc_pkg::REG_RADIUS:   cur_radius = data;
			dctc_pkg::REG_ORDER:    cur_order = data[5:0];
			default: ;
		endcase
		if (addr != REG_UNLISTED) clear_set();
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(255) - 128;
			default: return $urandom;
		endcase
	endfunction

	stim_row_t dir_rows[] = '{
		'{0, 0, 0, 32'h00000000, 0, 0},
		'{0, 0, 0, 32'h00000000, 0, 0},
		'{0, 0, 0, 32'h00000000, 1, 32'h00000000},
		'{0, 0, 0, 32'h7fffffff, 0, 0},
		'{0, 0, 0, 32'h7fffffff, 0, 0},
		'{0, 0, 0, 32'h7fffffff, 1, 32'h7fffffff},
		'{0, 0, 0, 32'h80000000, 0, 0},
		'{0, 0, 0, 32'h80000000, 0, 0},
		'{0, 0, 0, 32'h80000000, 1, 32'h80000000},
		'{1, dctc_pkg::REG_ORDER, 8'hff, 0, 0, 0},
		'{1, dctc_pkg::REG_DCT_TYPE, 8'hff, 0, 0, 0},
		'{1, dctc_pkg::REG_RADIUS, 8'h00, 0, 0, 0},
		'{0, 0, 0, 32'h12345678, 0, 0},
		'{0, 0, 0, 32'hffffffff, 0, 0},
		'{0, 0, 0, 32'h00000001, 0, 0},
		'{1, REG_UNLISTED, 8'h55, 0, 0, 0},
		'{1, dctc_pkg::REG_RADIUS, 8'h02, 0, 0, 0},
		'{1, dctc_pkg::REG_DCT_TYPE, 8'h01, 0, 0, 0},
		'{1, dctc_pkg::REG_ORDER, 8'h05, 0, 0, 0},
		'{0, 0, 0, 32'h40000000, 0, 0},
		'{0, 0, 0, 32'hc0000000, 0, 0},
		// A register write in the middle of a set drops the partial sums.
		'{1, dctc_pkg::REG_DCT_TYPE, 8'h02, 0, 0, 0},
		'{0, 0, 0, 32'h2aaaaaaa, 0, 0},
		'{0, 0, 0, 32'hd5555555, 0, 0},
		'{0, 0, 0, 32'h00010000, 0, 0},
		'{0, 0, 0, 32'hfffe0000, 0, 0},
		'{0, 0, 0, 32'h3fffffff, 0, 0}
	};

	initial begin
		int rand_items;
		int set_len;
		cur_type = 0;
		cur_radius = 1;
		cur_order = 0;
		clear_set();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_reg(dir_rows[i].addr, dir_rows[i].wdata);
			end else begin
				send_sample(dir_rows[i].sample);
				if (dir_rows[i].has_exp) coef_q[coef_q.size() - 1].coef = dir_rows[i].exp_coef;
			end
		end

		rand_items = 0;
		while (rand_items < 160) begin
			write_reg(dctc_pkg::REG_DCT_TYPE, 8'($urandom));
			write_reg(dctc_pkg::REG_RADIUS, ($urandom_range(9) == 0) ?
				8'($urandom_range(255, 8)) : 8'($urandom_range(4)));
			write_reg(dctc_pkg::REG_ORDER, ($urandom_range(3) == 0) ? 8'($urandom) :
				8'($urandom_range(7)));
			set_len = 2 * ((cur_radius == 0) ? 1 : int'(cur_radius)) + 1;
			if (set_len > 17) write_reg(dctc_pkg::REG_RADIUS, 8'($urandom_range(4) + 1));
			set_len = 2 * ((cur_radius == 0) ? 1 : int'(cur_radius)) + 1;
			for (int s = 0; s < $urandom_range(2, 1); s++) begin
				for (int i = 0; i < set_len; i++) send_sample(rand_sample());
				rand_items += set_len;
			end
			// Occasionally leave a set unfinished before the next write.
			if ($urandom_range(3) == 0) begin
				send_sample(rand_sample());
				rand_items++;
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (coef_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/dctc_pkg.sv
hw/rtl/dctc_ram.sv
hw/rtl/dctc_div.sv
hw/rtl/dctc_cos.sv
hw/rtl/kernel_dct_coefficients.sv
hw/rtl/dctc_checker.sv
verif/tb_kernel_dct_coefficients.sv
